// File: src/sgcp_pkg.sv
// sgcp_pkg: shared constants, request codes and controller/datapath handshake
// types for the scatter-gather copy planner
// no dependencies
package sgcp_pkg;

  // defaults for the top-level parameters
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int ADDR_BITS_DEF   = 32;

  // fixed field widths of the request and segment transactions
  localparam int TYPE_W  = 2;
  localparam int INDEX_W = 4;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 13;
  localparam int LIST_W  = 5;
  localparam int COUNT_W = 24;

  // segment limit per copy request
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // request codes
  localparam logic [TYPE_W-1:0] REQ_LOAD_SRC = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_LOAD_DST = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_COPY     = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_src;
    logic load_dst;
    logic start;
    logic skip;
    logic walk;
    logic finish;
  } sgcp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic skip_more;
    logic walk_more;
    logic push_busy;
    logic out_free;
  } sgcp_status_t;

endpackage

// File: src/sgcp_req_if.sv
// sgcp_req_if: request channel (descriptor loads and copy starts)
// depends on sgcp_pkg
interface sgcp_req_if;
  logic                          valid;
  logic                          ready;
  logic [sgcp_pkg::TYPE_W-1:0]   req_type;
  logic [sgcp_pkg::INDEX_W-1:0]  entry_index;
  logic [sgcp_pkg::ADDR_W-1:0]   entry_addr;
  logic [sgcp_pkg::LEN_W-1:0]    entry_len;
  logic [sgcp_pkg::LIST_W-1:0]   src_list_len;
  logic [sgcp_pkg::LIST_W-1:0]   dst_list_len;
  logic [sgcp_pkg::COUNT_W-1:0]  start_offset;
  logic [sgcp_pkg::COUNT_W-1:0]  byte_count;

  modport source (
    output valid, req_type, entry_index, entry_addr, entry_len,
           src_list_len, dst_list_len, start_offset, byte_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_addr, entry_len,
           src_list_len, dst_list_len, start_offset, byte_count,
    output ready
  );
endinterface

// File: src/sgcp_seg_if.sv
// sgcp_seg_if: copy segment channel
// depends on sgcp_pkg
interface sgcp_seg_if;
  logic                          valid;
  logic                          ready;
  logic [sgcp_pkg::ADDR_W-1:0]   seg_src_addr;
  logic [sgcp_pkg::ADDR_W-1:0]   seg_dst_addr;
  logic [sgcp_pkg::LEN_W-1:0]    seg_len;
  logic                          last;
  logic [sgcp_pkg::COUNT_W-1:0]  copied_total;

  modport source (
    output valid, seg_src_addr, seg_dst_addr, seg_len, last, copied_total,
    input  ready
  );
  modport sink (
    input  valid, seg_src_addr, seg_dst_addr, seg_len, last, copied_total,
    output ready
  );
endinterface

// File: src/sgcp_ram.sv
// sgcp_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module sgcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/sgcp_ctrl.sv
// sgcp_ctrl: request handshake and copy sequencing state machine
// depends on sgcp_pkg; drives sgcp_dp through sgcp_cmd_t
module sgcp_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic [sgcp_pkg::TYPE_W-1:0]  req_type,
  output logic                         req_ready,
  input  sgcp_pkg::sgcp_status_t       status,
  output sgcp_pkg::sgcp_cmd_t          cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req_type)
            sgcp_pkg::REQ_LOAD_SRC: cmd.load_src = 1'b1;
            sgcp_pkg::REQ_LOAD_DST: cmd.load_dst = 1'b1;
            sgcp_pkg::REQ_COPY: begin
              cmd.start  = 1'b1;
              state_next = ST_SKIP;
            end
            default: ;
          endcase
        end
      end
      ST_SKIP: begin
        if (status.skip_more) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.walk_more) begin
          // a step that retires the held segment waits for the output register
          if (!status.push_busy || status.out_free) begin
            cmd.walk = 1'b1;
          end
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// File: src/sgcp_dp.sv
// sgcp_dp: descriptor tables, list walk registers, held segment and output register
// depends on sgcp_pkg and sgcp_ram; commanded by sgcp_ctrl
module sgcp_dp #(
  parameter int MAX_ENTRIES = sgcp_pkg::MAX_ENTRIES_DEF,
  parameter int PAGE_BYTES  = sgcp_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_BITS   = sgcp_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sgcp_pkg::sgcp_cmd_t            cmd,
  output sgcp_pkg::sgcp_status_t         status,
  input  logic [sgcp_pkg::INDEX_W-1:0]   entry_index,
  input  logic [sgcp_pkg::ADDR_W-1:0]    entry_addr,
  input  logic [sgcp_pkg::LEN_W-1:0]     entry_len,
  input  logic [sgcp_pkg::LIST_W-1:0]    src_list_len,
  input  logic [sgcp_pkg::LIST_W-1:0]    dst_list_len,
  input  logic [sgcp_pkg::COUNT_W-1:0]   start_offset,
  input  logic [sgcp_pkg::COUNT_W-1:0]   byte_count,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [sgcp_pkg::ADDR_W-1:0]    seg_src_addr,
  output logic [sgcp_pkg::ADDR_W-1:0]    seg_dst_addr,
  output logic [sgcp_pkg::LEN_W-1:0]     seg_len,
  output logic                           last,
  output logic [sgcp_pkg::COUNT_W-1:0]   copied_total
);
  localparam int LEN_W   = sgcp_pkg::LEN_W;
  localparam int COUNT_W = sgcp_pkg::COUNT_W;
  localparam int ADDR_W  = sgcp_pkg::ADDR_W;
  localparam int RES_W   = sgcp_pkg::RES_W;
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W   = ADDR_BITS + LEN_W;

  // descriptor write path
  logic              slot_ok;
  logic [LEN_W-1:0]  len_sat;
  logic [ENT_W-1:0]  wdata;
  logic [IDX_W-1:0]  waddr;

  // descriptor read path
  logic [ENT_W-1:0]     src_rdata, dst_rdata;
  logic [ADDR_BITS-1:0] s_addr, d_addr;
  logic [LEN_W-1:0]     s_len, d_len;

  // walk registers
  logic [CNT_W-1:0]   si, si_next, di, di_next, ns, ns_next, nd, nd_next;
  logic [COUNT_W-1:0] so, so_next, left, left_next, count, count_next;
  logic [LEN_W-1:0]   dofs, dofs_next;
  logic [RES_W-1:0]   nres, nres_next;

  // held segment, retired once the next one or the end is known
  logic              pend_valid, pend_valid_next;
  logic [ADDR_W-1:0] pend_src, pend_src_next, pend_dst, pend_dst_next;
  logic [LEN_W-1:0]  pend_len, pend_len_next;

  logic              out_valid_next, last_next;
  logic [ADDR_W-1:0] seg_src_addr_next, seg_dst_addr_next;
  logic [LEN_W-1:0]  seg_len_next;
  logic [COUNT_W-1:0] copied_total_next;

  // step arithmetic
  logic [COUNT_W-1:0]   src_room, dst_room, n_sd, n;
  logic [COUNT_W-1:0]   so_adv;
  logic [LEN_W-1:0]     n_len, dofs_adv;
  logic                 src_done, dst_done;
  logic [ADDR_BITS-1:0] src_sum, dst_sum;
  logic [ADDR_W-1:0]    cur_src, cur_dst;
  logic [CNT_W-1:0]     ns_in, nd_in;

  assign slot_ok = (int'(entry_index) < MAX_ENTRIES);
  assign len_sat = (int'(entry_len) > PAGE_BYTES) ? LEN_W'(PAGE_BYTES) : entry_len;
  assign wdata   = {ADDR_BITS'(entry_addr), len_sat};
  assign waddr   = IDX_W'(entry_index);

  sgcp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_src_ram (
    .clk   (clk),
    .we    (cmd.load_src && slot_ok),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (si_next[IDX_W-1:0]),
    .rdata (src_rdata)
  );

  sgcp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_dst_ram (
    .clk   (clk),
    .we    (cmd.load_dst && slot_ok),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (di_next[IDX_W-1:0]),
    .rdata (dst_rdata)
  );

  assign s_addr = src_rdata[ENT_W-1:LEN_W];
  assign s_len  = src_rdata[LEN_W-1:0];
  assign d_addr = dst_rdata[ENT_W-1:LEN_W];
  assign d_len  = dst_rdata[LEN_W-1:0];

  assign ns_in = (int'(src_list_len) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                    : CNT_W'(src_list_len);
  assign nd_in = (int'(dst_list_len) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                    : CNT_W'(dst_list_len);

  // segment length: least of source room, destination room and bytes left
  assign src_room = COUNT_W'(s_len) - so;
  assign dst_room = COUNT_W'(d_len - dofs);
  assign n_sd     = (dst_room < src_room) ? dst_room : src_room;
  assign n        = (left < n_sd) ? left : n_sd;
  assign n_len    = LEN_W'(n);
  assign so_adv   = so + n;
  assign dofs_adv = dofs + n_len;
  assign src_done = (so_adv >= COUNT_W'(s_len));
  assign dst_done = (dofs_adv >= d_len);
  // addresses wrap at the address width
  assign src_sum  = s_addr + ADDR_BITS'(so);
  assign dst_sum  = d_addr + ADDR_BITS'(dofs);
  assign cur_src  = ADDR_W'(src_sum);
  assign cur_dst  = ADDR_W'(dst_sum);

  assign status.skip_more = (si < ns) && (so >= COUNT_W'(s_len));
  assign status.walk_more = (si < ns) && (di < nd) && (left != '0)
                            && (nres < RES_W'(sgcp_pkg::MAX_RESULTS));
  assign status.push_busy = (n != '0) && pend_valid;
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    si_next           = si;
    di_next           = di;
    ns_next           = ns;
    nd_next           = nd;
    so_next           = so;
    dofs_next         = dofs;
    left_next         = left;
    count_next        = count;
    nres_next         = nres;
    pend_valid_next   = pend_valid;
    pend_src_next     = pend_src;
    pend_dst_next     = pend_dst;
    pend_len_next     = pend_len;
    out_valid_next    = out_valid && !out_ready;
    seg_src_addr_next = seg_src_addr;
    seg_dst_addr_next = seg_dst_addr;
    seg_len_next      = seg_len;
    last_next         = last;
    copied_total_next = copied_total;

    if (cmd.start) begin
      si_next         = '0;
      di_next         = '0;
      ns_next         = ns_in;
      nd_next         = nd_in;
      so_next         = start_offset;
      dofs_next       = '0;
      left_next       = byte_count;
      count_next      = byte_count;
      nres_next       = '0;
      pend_valid_next = 1'b0;
    end

    if (cmd.skip) begin
      so_next = so - COUNT_W'(s_len);
      si_next = si + CNT_W'(1);
    end

    if (cmd.walk) begin
      left_next = left - n;
      if (src_done) begin
        so_next = '0;
        si_next = si + CNT_W'(1);
      end else begin
        so_next = so_adv;
      end
      if (dst_done) begin
        dofs_next = '0;
        di_next   = di + CNT_W'(1);
      end else begin
        dofs_next = dofs_adv;
      end
      if (n != '0) begin
        if (pend_valid) begin
          out_valid_next    = 1'b1;
          seg_src_addr_next = pend_src;
          seg_dst_addr_next = pend_dst;
          seg_len_next      = pend_len;
          last_next         = 1'b0;
          copied_total_next = '0;
        end
        pend_valid_next = 1'b1;
        pend_src_next   = cur_src;
        pend_dst_next   = cur_dst;
        pend_len_next   = n_len;
        nres_next       = nres + RES_W'(1);
      end
    end

    if (cmd.finish) begin
      out_valid_next = 1'b1;
      last_next      = 1'b1;
      if (pend_valid) begin
        seg_src_addr_next = pend_src;
        seg_dst_addr_next = pend_dst;
        seg_len_next      = pend_len;
        copied_total_next = count - left;
      end else begin
        // nothing copied: empty closing transaction
        seg_src_addr_next = '0;
        seg_dst_addr_next = '0;
        seg_len_next      = '0;
        copied_total_next = '0;
      end
      pend_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      si         <= '0;
      di         <= '0;
    end else begin
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
      si         <= si_next;
      di         <= di_next;
    end
    ns           <= ns_next;
    nd           <= nd_next;
    so           <= so_next;
    dofs         <= dofs_next;
    left         <= left_next;
    count        <= count_next;
    nres         <= nres_next;
    pend_src     <= pend_src_next;
    pend_dst     <= pend_dst_next;
    pend_len     <= pend_len_next;
    seg_src_addr <= seg_src_addr_next;
    seg_dst_addr <= seg_dst_addr_next;
    seg_len      <= seg_len_next;
    last         <= last_next;
    copied_total <= copied_total_next;
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (seg_len == '0) |-> last && (copied_total == '0))
    else $error("zero-length segment that is not an empty closing transaction");

  a_mid_has_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (seg_len != '0) && (copied_total == '0))
    else $error("intermediate segment with zero length or a total");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !pend_valid && (nres == '0))
    else $error("held segment survived a copy start");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(seg_len) <= PAGE_BYTES))
    else $error("segment longer than a page");

  a_walk_progress: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |=> (si != $past(si)) || (di != $past(di)) || (left == '0))
    else $error("walk step advanced neither list");
endmodule

// File: src/scatter_gather_copy_planner.sv
// Scatter-gather copy planner. A request transaction either loads one source or
// destination descriptor (address, length; lengths above PAGE_BYTES saturate,
// slots at or past MAX_ENTRIES are dropped) or starts a copy. A load gives no
// segment. A copy skips source descriptors up to start_offset, then walks both
// lists and emits segments (source address, destination address, length), the
// final one with last set and the byte total; a copy that moves no bytes gives
// one all-zero segment with last set. One request is handled at a time: a copy
// holds the request channel through its skip steps (one per source descriptor
// skipped) and its walk steps (at most src_list_len + dst_list_len), and a walk
// step that retires the held segment waits while the segment channel stalls.
// Each skip or walk step is paced by the one read per cycle of each descriptor
// RAM. The segment channel has its own output register, so the next request is
// taken while the final segment still waits.
// depends on sgcp_pkg, sgcp_req_if, sgcp_seg_if, sgcp_ctrl, sgcp_dp
module scatter_gather_copy_planner #(
  parameter int MAX_ENTRIES = sgcp_pkg::MAX_ENTRIES_DEF,
  parameter int PAGE_BYTES  = sgcp_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_BITS   = sgcp_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sgcp_req_if.sink    req,
  sgcp_seg_if.source  seg
);
  sgcp_pkg::sgcp_cmd_t    cmd;
  sgcp_pkg::sgcp_status_t status;

  sgcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sgcp_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PAGE_BYTES  (PAGE_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .entry_index  (req.entry_index),
    .entry_addr   (req.entry_addr),
    .entry_len    (req.entry_len),
    .src_list_len (req.src_list_len),
    .dst_list_len (req.dst_list_len),
    .start_offset (req.start_offset),
    .byte_count   (req.byte_count),
    .out_ready    (seg.ready),
    .out_valid    (seg.valid),
    .seg_src_addr (seg.seg_src_addr),
    .seg_dst_addr (seg.seg_dst_addr),
    .seg_len      (seg.seg_len),
    .last         (seg.last),
    .copied_total (seg.copied_total)
  );
endmodule

// File: verif/scatter_gather_copy_planner_tb.sv
`timescale 1ns / 100ps
// scatter_gather_copy_planner_tb: fills both descriptor tables, drives copy requests
// and checks every copy segment against a built-in copy planner with its own tables
// depends on sgcp_pkg, sgcp_req_if, sgcp_seg_if and scatter_gather_copy_planner
module scatter_gather_copy_planner_tb;

  localparam logic [sgcp_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned ENTRIES        = sgcp_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned PAGE           = sgcp_pkg::PAGE_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS   = 115;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 64;

  typedef struct packed {
    logic [sgcp_pkg::TYPE_W-1:0]  req_type;
    logic [sgcp_pkg::INDEX_W-1:0] entry_index;
    logic [sgcp_pkg::ADDR_W-1:0]  entry_addr;
    logic [sgcp_pkg::LEN_W-1:0]   entry_len;
    logic [sgcp_pkg::LIST_W-1:0]  src_list_len;
    logic [sgcp_pkg::LIST_W-1:0]  dst_list_len;
    logic [sgcp_pkg::COUNT_W-1:0] start_offset;
    logic [sgcp_pkg::COUNT_W-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [sgcp_pkg::ADDR_W-1:0]  src_addr;
    logic [sgcp_pkg::ADDR_W-1:0]  dst_addr;
    logic [sgcp_pkg::LEN_W-1:0]   len;
    logic                         last;
    logic [sgcp_pkg::COUNT_W-1:0] total;
  } seg_t;

  class copy_plan_scoreboard;
    logic [sgcp_pkg::ADDR_W-1:0] src_addr_tab [ENTRIES];
    int unsigned                 src_len_tab  [ENTRIES];
    logic [sgcp_pkg::ADDR_W-1:0] dst_addr_tab [ENTRIES];
    int unsigned                 dst_len_tab  [ENTRIES];
    seg_t                        expected_segs [$];
    int unsigned                 mismatches;

    function int unsigned pending();
      return expected_segs.size();
    endfunction

    // bytes held by the first n source descriptors
    function int unsigned src_bytes(int unsigned n);
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < n && i < ENTRIES; i++) sum += src_len_tab[i];
      return sum;
    endfunction

    function void plan_copy(req_t r);
      int unsigned ns, nd, si, di, nres;
      longint unsigned off, cnt, left, acc, so, dofs, slen, dlen, n, a;
      seg_t s;
      ns = (r.src_list_len > ENTRIES) ? ENTRIES : 32'(r.src_list_len);
      nd = (r.dst_list_len > ENTRIES) ? ENTRIES : 32'(r.dst_list_len);
      off = r.start_offset;
      cnt = r.byte_count;
      left = cnt;
      acc = 0;
      so = 0;
      dofs = 0;
      si = 0;
      di = 0;
      nres = 0;
      if (cnt != 0 && ns != 0 && nd != 0) begin
        // step over whole source descriptors lying before the offset
        while (si < ns && off >= acc + src_len_tab[si]) begin
          acc += src_len_tab[si];
          si++;
        end
        so = off - acc;
        while (si < ns && di < nd && left != 0 && nres < sgcp_pkg::MAX_RESULTS) begin
          slen = src_len_tab[si];
          dlen = dst_len_tab[di];
          n = slen - so;
          if (dlen - dofs < n) n = dlen - dofs;
          if (left < n) n = left;
          if (n != 0) begin
            a = src_addr_tab[si] + so;
            s.src_addr = a[sgcp_pkg::ADDR_W-1:0];
            a = dst_addr_tab[di] + dofs;
            s.dst_addr = a[sgcp_pkg::ADDR_W-1:0];
            s.len = n[sgcp_pkg::LEN_W-1:0];
            s.last = 1'b0;
            s.total = '0;
            expected_segs.push_back(s);
            nres++;
          end
          left -= n;
          so += n;
          if (so >= slen) begin
            so = 0;
            si++;
          end
          dofs += n;
          if (dofs >= dlen) begin
            dofs = 0;
            di++;
          end
        end
      end
      if (nres == 0) begin
        s = '0;
        s.last = 1'b1;
        expected_segs.push_back(s);
      end else begin
        s = expected_segs.pop_back();
        s.last = 1'b1;
        a = cnt - left;
        s.total = a[sgcp_pkg::COUNT_W-1:0];
        expected_segs.push_back(s);
      end
    endfunction

    function void note_request(req_t r);
      int unsigned len;
      len = (r.entry_len > PAGE) ? PAGE : 32'(r.entry_len);
      case (r.req_type)
        sgcp_pkg::REQ_LOAD_SRC: begin
          if (r.entry_index < ENTRIES) begin
            src_addr_tab[r.entry_index] = r.entry_addr;
            src_len_tab[r.entry_index] = len;
          end
        end
        sgcp_pkg::REQ_LOAD_DST: begin
          if (r.entry_index < ENTRIES) begin
            dst_addr_tab[r.entry_index] = r.entry_addr;
            dst_len_tab[r.entry_index] = len;
          end
        end
        sgcp_pkg::REQ_COPY: plan_copy(r);
        default: ;
      endcase
    endfunction

    function void check_segment(seg_t got);
      seg_t want;
      if (expected_segs.size() == 0) begin
        $error("unexpected segment transaction: src %h dst %h len %0d last %0b total %0d",
               got.src_addr, got.dst_addr, got.len, got.last, got.total);
        mismatches++;
      end else begin
        want = expected_segs.pop_front();
        if (got.src_addr !== want.src_addr) begin
          $error("seg_src_addr: expected %h, actual %h", want.src_addr, got.src_addr);
          mismatches++;
        end
        if (got.dst_addr !== want.dst_addr) begin
          $error("seg_dst_addr: expected %h, actual %h", want.dst_addr, got.dst_addr);
          mismatches++;
        end
        if (got.len !== want.len) begin
          $error("seg_len: expected %0d, actual %0d", want.len, got.len);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, got.last);
          mismatches++;
        end
        if (got.total !== want.total) begin
          $error("copied_total: expected %0d, actual %0d", want.total, got.total);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  bit                  steady;
  int unsigned         sink_hold;
  int unsigned         idle_cycles;
  copy_plan_scoreboard sb;

  sgcp_req_if req_ch ();
  sgcp_seg_if seg_ch ();

  scatter_gather_copy_planner dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .seg (seg_ch)
  );

  always #5 clk = ~clk;

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic req_t noise_req();
    logic [127:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(req_t)-1:0];
  endfunction

  function automatic req_t load_req(logic [sgcp_pkg::TYPE_W-1:0] kind, int unsigned idx,
                                    logic [sgcp_pkg::ADDR_W-1:0] addr, int unsigned len);
    req_t r;
    r = noise_req();
    r.req_type = kind;
    r.entry_index = sgcp_pkg::INDEX_W'(idx);
    r.entry_addr = addr;
    r.entry_len = sgcp_pkg::LEN_W'(len);
    return r;
  endfunction

  function automatic req_t copy_req(int unsigned ns, int unsigned nd, int unsigned off,
                                    int unsigned cnt);
    req_t r;
    r = noise_req();
    r.req_type = sgcp_pkg::REQ_COPY;
    r.src_list_len = sgcp_pkg::LIST_W'(ns);
    r.dst_list_len = sgcp_pkg::LIST_W'(nd);
    r.start_offset = sgcp_pkg::COUNT_W'(off);
    r.byte_count = sgcp_pkg::COUNT_W'(cnt);
    return r;
  endfunction

  function automatic req_t random_load();
    logic [sgcp_pkg::TYPE_W-1:0] kind;
    logic [sgcp_pkg::ADDR_W-1:0] addr;
    int unsigned                 len, pick;
    kind = ($urandom_range(1, 0) == 1) ? sgcp_pkg::REQ_LOAD_DST : sgcp_pkg::REQ_LOAD_SRC;
    // some descriptors sit just below the top of the address space to force wrap
    addr = ($urandom_range(99, 0) < 15) ? (32'hFFFF_F000 | $urandom_range(4095, 0))
                                        : $urandom();
    pick = $urandom_range(99, 0);
    if (pick < 8) len = 0;
    else if (pick < 20) len = $urandom_range(8191, PAGE + 1);
    else len = $urandom_range(PAGE, 1);
    return load_req(kind, $urandom_range(ENTRIES - 1, 0), addr, len);
  endfunction

  function automatic int unsigned random_list_len();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 8) return 0;
    if (pick < 16) return $urandom_range(31, ENTRIES + 1);
    return $urandom_range(ENTRIES, 1);
  endfunction

  function automatic req_t random_copy();
    int unsigned ns, nd, span, off, cnt, pick;
    ns = random_list_len();
    nd = random_list_len();
    span = sb.src_bytes(ns);
    pick = $urandom_range(99, 0);
    if (pick < 70) off = $urandom_range(span, 0);
    else if (pick < 85) off = sb.src_bytes($urandom_range(ns, 0));
    else off = $urandom() & 32'h00FF_FFFF;
    pick = $urandom_range(99, 0);
    if (pick < 5) cnt = 0;
    else if (pick < 15) cnt = $urandom() & 32'h00FF_FFFF;
    else if (pick < 35) cnt = $urandom_range(16, 1);
    else cnt = $urandom_range(span + PAGE, 1);
    return copy_req(ns, nd, off, cnt);
  endfunction

  task automatic send(req_t r);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.req_type = r.req_type;
    req_ch.entry_index = r.entry_index;
    req_ch.entry_addr = r.entry_addr;
    req_ch.entry_len = r.entry_len;
    req_ch.src_list_len = r.src_list_len;
    req_ch.dst_list_len = r.dst_list_len;
    req_ch.start_offset = r.start_offset;
    req_ch.byte_count = r.byte_count;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // hold off new requests until every outstanding segment has arrived
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (sink_hold == 0 && !steady) sink_hold = pick_gap();
    if (sink_hold != 0) begin
      seg_ch.ready = 1'b0;
      sink_hold--;
    end else begin
      seg_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (seg_ch.valid && seg_ch.ready) begin
        sb.check_segment({seg_ch.seg_src_addr, seg_ch.seg_dst_addr, seg_ch.seg_len,
                          seg_ch.last, seg_ch.copied_total});
        idle_cycles = 0;
      end
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request({req_ch.req_type, req_ch.entry_index, req_ch.entry_addr,
                         req_ch.entry_len, req_ch.src_list_len, req_ch.dst_list_len,
                         req_ch.start_offset, req_ch.byte_count});
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    req_t        r;
    int unsigned done_items, sent, pick;
    sb = new();
    rst = 1'b1;
    steady = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = sgcp_pkg::REQ_LOAD_SRC;
    req_ch.entry_index = '0;
    req_ch.entry_addr = '0;
    req_ch.entry_len = '0;
    req_ch.src_list_len = '0;
    req_ch.dst_list_len = '0;
    req_ch.start_offset = '0;
    req_ch.byte_count = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every slot holds a descriptor before any copy can read it
    for (int k = 0; k < ENTRIES; k++) begin
      send(load_req(sgcp_pkg::REQ_LOAD_SRC, k, $urandom(), $urandom_range(PAGE, 1)));
      send(load_req(sgcp_pkg::REQ_LOAD_DST, k, $urandom(), $urandom_range(PAGE, 1)));
    end
    steady = 1'b0;

    send(load_req(sgcp_pkg::REQ_LOAD_SRC, 0, 32'h0000_0000, 1));
    send(load_req(sgcp_pkg::REQ_LOAD_SRC, 1, 32'hFFFF_FF00, PAGE));
    send(load_req(sgcp_pkg::REQ_LOAD_SRC, 2, $urandom(), 0));
    send(load_req(sgcp_pkg::REQ_LOAD_SRC, 3, $urandom(), 8191));
    send(load_req(sgcp_pkg::REQ_LOAD_DST, ENTRIES - 1, 32'hFFFF_FFFF, PAGE + 1));
    send(load_req(sgcp_pkg::REQ_LOAD_DST, 0, $urandom(), 0));
    r = noise_req();
    r.req_type = REQ_UNUSED;
    send(r);
    send(copy_req(ENTRIES, ENTRIES, 0, 0));
    send(copy_req(0, ENTRIES, 0, 100));
    send(copy_req(ENTRIES, 0, 0, 100));
    send(copy_req(ENTRIES, ENTRIES, 24'hFF_FFFF, 24'hFF_FFFF));
    send(copy_req(31, 31, 0, 24'hFF_FFFF));
    send(copy_req(4, 4, 1, 1));
    // offset lands on the empty descriptor and must move past it
    send(copy_req(5, 2, 1 + PAGE, 5000));
    send(copy_req(1, 1, 0, 1));
    send(copy_req(ENTRIES, 1, 0, 24'hFF_FFFF));
    send(copy_req(1, ENTRIES, 0, 24'hFF_FFFF));
    send(copy_req(ENTRIES, ENTRIES, sb.src_bytes(ENTRIES), 24'hFF_FFFF));
    drain();

    done_items = 0;
    sent = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (sent % 25 == 0) steady = ($urandom_range(3, 0) == 0);
      if (sent % 40 == 39 && $urandom_range(1, 0) == 1) drain();
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
        r = noise_req();
        r.req_type = REQ_UNUSED;
        send(r);
      end else begin
        if (pick < 35) send(random_load());
        else send(random_copy());
        done_items++;
      end
      sent++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: scatter_gather_copy_planner.f
src/sgcp_pkg.sv
src/sgcp_req_if.sv
src/sgcp_seg_if.sv
src/sgcp_ram.sv
src/sgcp_ctrl.sv
src/sgcp_dp.sv
src/scatter_gather_copy_planner.sv
verif/scatter_gather_copy_planner_tb.sv
